### hdl/pstack_pkg.sv
// ----------------------------------------------------------------------------
// pstack_pkg
// Shared types and operation codes for the persistent stack block.
// ----------------------------------------------------------------------------
`default_nettype none

package pstack_pkg;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 4;
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 11;
    // Slot field reaches this many table entries at most
    localparam int SLOT_REACH = 16;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SAVE = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // an item is taken this cycle
        logic push;       // append node, move head
        logic pop_read;   // read node at head
        logic save;       // copy head/depth to slot
        logic load;       // restore head/depth, read node at new head
        logic pop_link;   // follow link, read node at new head
        logic take_value; // latch read value as top
        logic emit;       // load result register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic head_none;
    } t_stat;

endpackage

`default_nettype wire

### hdl/persistent_stack_with_snapshots.sv
// ----------------------------------------------------------------------------
// persistent_stack_with_snapshots
// Versioned stack in an append-only node pool with save/load snapshot slots.
// Each item is an operation: push, pop, save to a slot or load from a slot.
// Every item returns one result: the top value (-1 when empty), the empty
// flag, the depth, and a flag set only when a push was dropped because the
// pool is out of nodes. Nodes are never reclaimed. A slot never saved, or one
// at or beyond SNAPSHOT_SLOTS, loads an empty stack. An item is taken only
// when the block is idle; push and save need no node read, a load needs one
// for the new top, and a pop of a non-empty stack needs two dependent reads,
// the old head's link and then the new head's value, since the node memory
// has a registered read port. The result sits in an output register, so the
// next item is taken while a result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module persistent_stack_with_snapshots #(
    parameter int POOL_NODES     = 1024,
    parameter int SNAPSHOT_SLOTS = 16,
    parameter int VALUE_BITS     = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [pstack_pkg::OP_W-1:0]         i_operation,
    input  wire logic signed [pstack_pkg::DATA_W-1:0] i_push_value,
    input  wire logic [pstack_pkg::SLOT_W-1:0]       i_slot,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [pstack_pkg::DATA_W-1:0]     o_top_value,
    output logic                                     o_is_empty,
    output logic [pstack_pkg::DEPTH_W-1:0]           o_depth,
    output logic                                     o_pool_full
);
    import pstack_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer: decodes the operation, paces the node memory reads
    pstack_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Storage and result: node pool, version registers, slot table
    pstack_dp #(
        .POOL_NODES     (POOL_NODES),
        .SNAPSHOT_SLOTS (SNAPSHOT_SLOTS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_push_value),
        .i_slot       (i_slot),
        .o_stat       (stat),
        .o_top_value  (o_top_value),
        .o_is_empty   (o_is_empty),
        .o_depth      (o_depth),
        .o_pool_full  (o_pool_full)
    );

endmodule

`default_nettype wire

### hdl/pstack_ctrl.sv
// ----------------------------------------------------------------------------
// pstack_ctrl
// Sequencer: accepts an item, steps through node reads, hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module pstack_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [pstack_pkg::OP_W-1:0] i_operation,
    input  wire logic                      i_out_stall,
    input  wire pstack_pkg::t_stat         i_stat,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output pstack_pkg::t_cmd               o_cmd
);
    import pstack_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LINK  = 2'd1;
    localparam logic [1:0] S_VALUE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    case (i_operation)
                        OP_PUSH: begin
                            cmd.push = 1'b1;
                            n_state  = S_DONE;
                        end
                        OP_POP: begin
                            if (!i_stat.head_none) begin
                                cmd.pop_read = 1'b1;
                                n_state      = S_LINK;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        OP_SAVE: begin
                            cmd.save = 1'b1;
                            n_state  = S_DONE;
                        end
                        OP_LOAD: begin
                            cmd.load = 1'b1;
                            n_state  = S_VALUE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LINK: begin
                cmd.pop_link = 1'b1;
                n_state      = S_VALUE;
            end
            S_VALUE: begin
                cmd.take_value = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = cmd.emit | (r_out_valid & i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result emitted over a pending item");

    // Pop of a non-empty stack always walks the link
    a_pop_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop_read |=> (r_state == S_LINK))
        else $error("pop did not enter link step");

    // Push and save finish without memory reads
    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.push || cmd.save) |=> (r_state == S_DONE))
        else $error("push/save took extra steps");

endmodule

`default_nettype wire

### hdl/pstack_dp.sv
// ----------------------------------------------------------------------------
// pstack_dp
// Datapath: node pool memory, head/depth/free registers, slot table, result.
// ----------------------------------------------------------------------------
`default_nettype none

module pstack_dp #(
    parameter int POOL_NODES     = 1024,
    parameter int SNAPSHOT_SLOTS = 16,
    parameter int VALUE_BITS     = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pstack_pkg::t_cmd                    i_cmd,
    input  wire logic signed [pstack_pkg::DATA_W-1:0] i_push_value,
    input  wire logic [pstack_pkg::SLOT_W-1:0]       i_slot,
    output pstack_pkg::t_stat                        o_stat,
    output logic signed [pstack_pkg::DATA_W-1:0]     o_top_value,
    output logic                                     o_is_empty,
    output logic [pstack_pkg::DEPTH_W-1:0]           o_depth,
    output logic                                     o_pool_full
);
    import pstack_pkg::*;

    localparam int IDX_W   = $clog2(POOL_NODES + 1);
    localparam int ADDR_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int NODE_W  = IDX_W + VALUE_BITS;
    localparam int SLOT_N  = (SNAPSHOT_SLOTS < SLOT_REACH) ? SNAPSHOT_SLOTS : SLOT_REACH;
    localparam int SLOT_IW = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
    localparam logic [IDX_W-1:0] NONE = IDX_W'(POOL_NODES);

    // Node pool: {link, value}, undefined until pushed
    logic [NODE_W-1:0] r_mem [POOL_NODES];
    logic [NODE_W-1:0] r_rd;

    logic [IDX_W-1:0]      r_head, r_depth, r_next_free;
    logic [VALUE_BITS-1:0] r_top;
    logic                  r_dropped;

    logic [IDX_W-1:0] r_slot_head  [SLOT_N];
    logic [IDX_W-1:0] r_slot_depth [SLOT_N];
    logic [SLOT_N-1:0] r_slot_vld;

    logic                  full;
    logic                  slot_ok;
    logic [SLOT_IW-1:0]    slot_idx;
    logic [IDX_W-1:0]      ld_head, ld_depth;
    logic [IDX_W-1:0]      rd_link;
    logic [VALUE_BITS-1:0] rd_value;
    logic [IDX_W-1:0]      rd_idx;
    logic                  rd_en;
    logic signed [63:0]    push_ext;
    logic signed [63:0]    top_ext;
    logic [31:0]           depth_wide;

    assign full     = (r_next_free == NONE);
    assign slot_ok  = (32'(i_slot) < SLOT_N);
    assign slot_idx = i_slot[SLOT_IW-1:0];
    assign ld_head  = (slot_ok && r_slot_vld[slot_idx]) ? r_slot_head[slot_idx] : NONE;
    assign ld_depth = (slot_ok && r_slot_vld[slot_idx]) ? r_slot_depth[slot_idx] : '0;
    assign rd_link  = r_rd[NODE_W-1:VALUE_BITS];
    assign rd_value = r_rd[VALUE_BITS-1:0];
    assign push_ext = 64'(i_push_value);

    always_comb begin
        rd_idx = r_head;
        if (i_cmd.load) begin
            rd_idx = ld_head;
        end else if (i_cmd.pop_link) begin
            rd_idx = rd_link;
        end
    end
    assign rd_en = (i_cmd.pop_read | i_cmd.load | i_cmd.pop_link) & (rd_idx != NONE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_next_free[ADDR_W-1:0]] <= {r_head, push_ext[VALUE_BITS-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_idx[ADDR_W-1:0]];
        end
    end

    // Stack version registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NONE;
            r_depth     <= '0;
            r_next_free <= '0;
            r_dropped   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_dropped <= i_cmd.push & full;
            end
            if (i_cmd.push && !full) begin
                r_head      <= r_next_free;
                r_depth     <= r_depth + 1'b1;
                r_next_free <= r_next_free + 1'b1;
            end
            if (i_cmd.load) begin
                r_head  <= ld_head;
                r_depth <= ld_depth;
            end
            if (i_cmd.pop_link) begin
                r_head <= rd_link;
                if (r_depth != '0) begin
                    r_depth <= r_depth - 1'b1;
                end
            end
        end
    end

    // Cached top value
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_top <= push_ext[VALUE_BITS-1:0];
        end else if (i_cmd.take_value) begin
            r_top <= rd_value;
        end
    end

    // Snapshot table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld <= '0;
        end else if (i_cmd.save && slot_ok) begin
            r_slot_vld[slot_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save && slot_ok) begin
            r_slot_head[slot_idx]  <= r_head;
            r_slot_depth[slot_idx] <= r_depth;
        end
    end

    // Result register
    assign top_ext    = 64'($signed(r_top));
    assign depth_wide = 32'(r_depth);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_top_value <= (r_head == NONE) ? '1 : top_ext[DATA_W-1:0];
            o_is_empty  <= (r_head == NONE);
            o_depth     <= depth_wide[DEPTH_W-1:0];
            o_pool_full <= r_dropped;
        end
    end

    assign o_stat.head_none = (r_head == NONE);

    a_depth_matches_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) == (r_depth == '0))
        else $error("depth and head disagree on emptiness");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= NONE)
        else $error("free pointer past pool");

    a_head_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NONE) || (r_head < r_next_free))
        else $error("head names an unwritten node");

endmodule

`default_nettype wire

### verif/persistent_stack_with_snapshots_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// persistent_stack_with_snapshots_test
// Self-checking bench for the versioned stack with snapshot slots.
// A short table of directed items covers the empty-stack corners, the value
// extremes, saves and loads, including a load of a slot that was never
// saved. A long random run follows. It includes a push-heavy stretch that
// exhausts the node pool, so dropped pushes show up too. Every accepted item
// runs through a local model of the stack. Each result is compared field by
// field with the oldest expected view. The sender works in bursts, and the
// receiver stalls in changing patterns, with one long hold-off.
// ----------------------------------------------------------------------------

module persistent_stack_with_snapshots_test;
    import pstack_pkg::*;

    localparam int POOL      = 1024;      // node pool size of the instance
    localparam int SLOTS     = 16;        // snapshot slots of the instance
    localparam logic [DEPTH_W-1:0] NO_NODE = DEPTH_W'(POOL);

    localparam int HOLD_START   = 1500;   // cycle where the long hold-off begins
    localparam int HOLD_LEN     = 400;    // cycles the receiver holds off
    localparam int DRAIN_CYCLES = 32;     // quiet cycles after the last result

    // What the block reports after an item
    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic                     is_empty;
        logic [DEPTH_W-1:0]       depth;
        logic                     pool_full;
    } t_stack_view;

    // One item of the script, with an optional hand-written expectation
    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [DATA_W-1:0] push_value;
        logic [SLOT_W-1:0]        slot;
        logic                     typed;
        t_stack_view              view;
    } t_stack_item;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_in_valid   = 1'b0;
    logic [OP_W-1:0]            i_operation  = OP_PUSH;
    logic signed [DATA_W-1:0]   i_push_value = '0;
    logic [SLOT_W-1:0]          i_slot       = '0;
    logic                       i_out_stall  = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic signed [DATA_W-1:0]   o_top_value;
    logic                       o_is_empty;
    logic [DEPTH_W-1:0]         o_depth;
    logic                       o_pool_full;

    persistent_stack_with_snapshots #(
        .POOL_NODES     (POOL),
        .SNAPSHOT_SLOTS (SLOTS),
        .VALUE_BITS     (DATA_W)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .i_slot       (i_slot),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_top_value  (o_top_value),
        .o_is_empty   (o_is_empty),
        .o_depth      (o_depth),
        .o_pool_full  (o_pool_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // Local copy of the stack: node pool, head, depth, slot table
    // ------------------------------------------------------------------
    logic [DATA_W-1:0]  node_val  [POOL];
    logic [DEPTH_W-1:0] node_next [POOL];
    logic [DEPTH_W-1:0] cur_head  = NO_NODE;
    logic [DEPTH_W-1:0] cur_depth = '0;
    logic [DEPTH_W-1:0] free_ptr  = '0;
    logic [DEPTH_W-1:0] saved_head  [SLOTS];
    logic [DEPTH_W-1:0] saved_depth [SLOTS];

    t_stack_item op_script [$];       // every item to send, in order
    t_stack_view pending_views [$];   // views still owed by the block
    int          mismatch_count = 0;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            saved_head[k]  = NO_NODE;
            saved_depth[k] = '0;
        end
    end

    // Apply one item to the local stack and return the view afterwards
    task automatic stack_apply(input t_stack_item it, output t_stack_view view);
        logic dropped;
        dropped = 1'b0;
        case (it.operation)
            OP_PUSH: begin
                if (int'(free_ptr) < POOL) begin
                    node_val[free_ptr]  = it.push_value;
                    node_next[free_ptr] = cur_head;
                    cur_head  = free_ptr;
                    free_ptr  = free_ptr + 1'b1;
                    cur_depth = cur_depth + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
            OP_POP: begin
                // pop of an empty stack leaves everything as it is
                if (cur_head != NO_NODE) begin
                    cur_head = node_next[cur_head];
                    if (cur_depth != 0) cur_depth = cur_depth - 1'b1;
                end
            end
            OP_SAVE: begin
                if (int'(it.slot) < SLOTS) begin
                    saved_head[it.slot]  = cur_head;
                    saved_depth[it.slot] = cur_depth;
                end
            end
            default: begin
                // a slot never saved still holds the empty stack from reset
                if (int'(it.slot) < SLOTS) begin
                    cur_head  = saved_head[it.slot];
                    cur_depth = saved_depth[it.slot];
                end else begin
                    cur_head  = NO_NODE;
                    cur_depth = '0;
                end
            end
        endcase
        view.top_value = (cur_head == NO_NODE) ? -32'sd1 : node_val[cur_head];
        view.is_empty  = (cur_head == NO_NODE);
        view.depth     = cur_depth;
        view.pool_full = dropped;
    endtask

    // ------------------------------------------------------------------
    // Stimulus script
    // ------------------------------------------------------------------
    task automatic add_row(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic [SLOT_W-1:0] s, input logic typed,
                           input logic [DATA_W-1:0] top, input logic empty,
                           input int depth, input logic full);
        t_stack_item it;
        it.operation      = op;
        it.push_value     = val;
        it.slot           = s;
        it.typed          = typed;
        it.view.top_value = top;
        it.view.is_empty  = empty;
        it.view.depth     = DEPTH_W'(depth);
        it.view.pool_full = full;
        op_script.insert(op_script.size(), it);
    endtask

    task automatic add_random(input int push_pct, inout int pushes);
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] val;
        int                r;
        r = $urandom_range(99);
        if (r < push_pct) begin
            op = OP_PUSH;
        end else begin
            // of the rest: half pops, a quarter each saves and loads
            r = $urandom_range(3);
            op = (r < 2) ? OP_POP : (r == 2) ? OP_SAVE : OP_LOAD;
        end
        case ($urandom_range(15))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
        endcase
        if (op == OP_PUSH) pushes++;
        add_row(op, val, SLOT_W'($urandom_range(15)), 1'b0, '0, 1'b0, 0, 1'b0);
    endtask

    task automatic build_script();
        int pushes;
        // directed table: typed rows read straight off the behavior
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd5,  1'b1, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_row(OP_SAVE, 32'hFFFF_FFFF, 4'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_row(OP_PUSH, 32'h7FFF_FFFF, 4'd15, 1'b1, 32'h7FFF_FFFF, 1'b0, 1, 1'b0);
        add_row(OP_PUSH, 32'h8000_0000, 4'd0,  1'b1, 32'h8000_0000, 1'b0, 2, 1'b0);
        add_row(OP_PUSH, 32'h0000_0000, 4'd0,  1'b1, 32'h0000_0000, 1'b0, 3, 1'b0);
        // a real -1 on top must not read as empty
        add_row(OP_PUSH, 32'hFFFF_FFFF, 4'd0,  1'b1, 32'hFFFF_FFFF, 1'b0, 4, 1'b0);
        add_row(OP_SAVE, 32'h1234_5678, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, 4, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b1, 32'h0000_0000, 1'b0, 3, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b1, 32'h8000_0000, 1'b0, 2, 1'b0);
        // branch off an older version
        add_row(OP_PUSH, 32'h1234_5678, 4'd9,  1'b1, 32'h1234_5678, 1'b0, 3, 1'b0);
        add_row(OP_SAVE, 32'h0000_0000, 4'd1,  1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_LOAD, 32'hFFFF_FFFF, 4'd15, 1'b1, 32'hFFFF_FFFF, 1'b0, 4, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b1, 32'h0000_0000, 1'b0, 3, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd0,  1'b1, 32'hFFFF_FFFF, 1'b1, 0, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd1,  1'b1, 32'h1234_5678, 1'b0, 3, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_POP,  32'h0000_0000, 4'd0,  1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_POP,  32'hFFFF_FFFF, 4'd15, 1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_SAVE, 32'h0000_0000, 4'd3,  1'b0, '0, 1'b0, 0, 1'b0);
        add_row(OP_LOAD, 32'h0000_0000, 4'd15, 1'b0, '0, 1'b0, 0, 1'b0);
        pushes = 5;
        // random: a mixed run, then a push-heavy run past pool exhaustion,
        // then a mixed run on the full pool (drops, pops, reloads)
        for (int k = 0; k < 150; k++) add_random(45, pushes);
        while (pushes < POOL + 24) add_random(90, pushes);
        for (int k = 0; k < 100; k++) add_random(35, pushes);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of items with random gaps; the model is updated at
    // the edge where an item is taken
    // ------------------------------------------------------------------
    initial begin : sender
        int          idx;
        int          burst_left;
        int          gap_left;
        t_stack_item it;
        t_stack_view predicted;
        build_script();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idx        = 0;
        burst_left = $urandom_range(1, 20);
        gap_left   = 0;
        while (idx < op_script.size()) begin
            @(posedge i_clk);
            if (i_in_valid && !o_in_stall) begin
                it = op_script[idx];
                stack_apply(it, predicted);
                pending_views.insert(pending_views.size(), it.typed ? it.view : predicted);
                idx++;
            end
            // a stalled item stays on the wires untouched
            if (!(i_in_valid && o_in_stall)) begin
                if (idx >= op_script.size() || gap_left > 0) begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    it = op_script[idx];
                    i_operation  <= it.operation;
                    i_push_value <= it.push_value;
                    i_slot       <= it.slot;
                    i_in_valid   <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        // one burst in four is long and back to back
                        burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 20);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        // all items taken: wait for the owed results, then a quiet tail
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: switches between random stall patterns; one long hold-off
    // lets the block fill up and stall its input
    // ------------------------------------------------------------------
    initial begin : receiver
        int cyc;
        int mode;
        cyc  = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
                i_out_stall <= 1'b1;
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(3);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(9) < 3);
                    2:       i_out_stall <= ($urandom_range(9) < 7);
                    default: i_out_stall <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint expv, input longint got);
        if (expv != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, expv, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_view want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result, expected none got top %0d depth %0d",
                         $time, o_top_value, o_depth);
                mismatch_count++;
            end else begin
                want = pending_views.pop_front();
                check_field("top_value", want.top_value, o_top_value);
                check_field("is_empty",  want.is_empty,  o_is_empty);
                check_field("depth",     want.depth,     o_depth);
                check_field("pool_full", want.pool_full, o_pool_full);
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hdl/pstack_pkg.sv
hdl/pstack_ctrl.sv
hdl/pstack_dp.sv
hdl/persistent_stack_with_snapshots.sv
verif/persistent_stack_with_snapshots_test.sv
